[hw/rtl/rqvg_pkg.sv]
package rqvg_pkg;

	// Default build parameters of the generator.
	localparam int ANGLE_BITS_DEF = 16;
	localparam int TRIG_ITER_DEF  = 16;

	// Depth of the arctangent table; the CORDIC never runs more iterations than this.
	localparam int ATAN_ENTRIES = 24;

	// Six vertices per quad, numbered by a three bit slot.
	localparam int          VERTS     = 6;
	localparam int          SLOT_W    = 3;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VERTS - 1);

	// Corner numbering: 0 = (-w/2,-h/2), 1 = (+w/2,-h/2), 2 = (+w/2,+h/2), 3 = (-w/2,+h/2).
	localparam logic [1:0] CORNER_0 = 2'd0;
	localparam logic [1:0] CORNER_1 = 2'd1;
	localparam logic [1:0] CORNER_2 = 2'd2;
	localparam logic [1:0] CORNER_3 = 2'd3;

	// Quadrant picked from the phase before the residual rotation.
	localparam logic [1:0] QUAD_EAST  = 2'd0;
	localparam logic [1:0] QUAD_NORTH = 2'd1;
	localparam logic [1:0] QUAD_WEST  = 2'd2;
	localparam logic [1:0] QUAD_SOUTH = 2'd3;

	// 1/K of an unlimited CORDIC in Q2.30.
	localparam logic signed [31:0] CORDIC_INIT_X = 32'sh26DD3B6A;

	// atan(2^-i) as a binary angle, 2^32 per turn.
	localparam logic signed [31:0] ATAN_PHASE [ATAN_ENTRIES] = '{
		32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
		32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
		32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
		32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
		32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
		32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
	};

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic        [15:0] angle;
		logic signed [31:0] size_x;
		logic signed [31:0] size_y;
		logic signed [31:0] tex_u0;
		logic signed [31:0] tex_v0;
		logic signed [31:0] tex_u1;
		logic signed [31:0] tex_v1;
		logic        [31:0] color_rgba;
	} sprite_t;

	typedef struct packed {
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_u;
		logic signed [31:0] vert_v;
		logic        [31:0] vert_color;
		logic  [SLOT_W-1:0] vert_slot;
		logic               last_vertex;
	} vertex_t;

	// Two triangles: corners 0,1,2 then 0,2,3.
	function automatic logic [1:0] slot_corner(input logic [SLOT_W-1:0] slot);
		logic [1:0] c;
		case (slot)
			3'd0: c = CORNER_0;
			3'd1: c = CORNER_1;
			3'd2: c = CORNER_2;
			3'd3: c = CORNER_0;
			3'd4: c = CORNER_2;
			3'd5: c = CORNER_3;
			default: c = CORNER_0;
		endcase
		return c;
	endfunction

endpackage

[hw/rtl/rotated_quad_vertex_generator.sv]
// Channel   Ports                    Direction  Transfer
// sprite    start, busy, sprite      in         edge with start high and busy low
// vertex    strobe, vertex           out        edge that ends the strobe cycle
//
// A sprite is taken only when busy is low; busy then stays high while the spacing counter
// runs down from LAST_SLOT, which is the time the output needs for the six vertices of one quad.
// A sprite passes the entry register, the CORDIC stages, stages 2 to 4, the hold register
// and the output register, and its six vertices then follow on consecutive cycles.
// The receiver cannot stall, so nothing inside ever waits: items only move forward.
// Reset clears the valid bits, the serializer and the spacing counter.
module rotated_quad_vertex_generator
	import rqvg_pkg::*;
#(
	parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
	parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  sprite_t sprite,
	output logic    strobe,
	output vertex_t vertex
);

	// Number of CORDIC iterations, one pipeline stage each.
	localparam int NUM_ITER = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;

	// Only the top ANGLE_BITS bits of the 32 bit phase take part.
	localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

	// Half of one unit in the last place after the shift by 47, for round to nearest.
	localparam logic signed [65:0] ROUND_HALF = 66'sd1 <<< 46;

	// ------------------------------------------------------------------
	// Input spacing. After each transfer the port refuses new sprites while
	// the counter runs down from LAST_SLOT, so that quads reach the serializer
	// no faster than it sends out their vertices and never overrun it.
	// ------------------------------------------------------------------
	logic [SLOT_W-1:0] gap_q;
	logic              accept;

	assign busy   = (gap_q != '0);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (accept) begin
			gap_q <= LAST_SLOT;
		end else if (gap_q != '0) begin
			gap_q <= gap_q - 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Angle reduction. The phase is split into the nearest quarter turn and
	// a residual in [-1/8, +1/8) turn; the residual drives the CORDIC and the
	// quarter turn is applied afterward by swapping and negating.
	// ------------------------------------------------------------------
	logic [31:0]        phase;
	logic [31:0]        phase_rnd;
	logic [1:0]         quad_in;
	logic signed [31:0] resid_in;

	assign phase     = {sprite.angle, 16'h0000} & PHASE_MASK;
	assign phase_rnd = phase + 32'h2000_0000;
	assign quad_in   = phase_rnd[31:30];
	assign resid_in  = $signed(phase - {quad_in, 30'd0});

	// ------------------------------------------------------------------
	// Stage group 1: the CORDIC, one rotation per register stage. Entry 0
	// holds the freshly taken sprite; entry k+1 holds it after rotation k.
	// x and y stay inside 32 bits since their magnitude never exceeds
	// about 2^30, and z stays within a quarter turn.
	// ------------------------------------------------------------------
	logic               v_s1     [NUM_ITER+1];
	logic signed [31:0] cx_s1    [NUM_ITER+1];
	logic signed [31:0] cy_s1    [NUM_ITER+1];
	logic signed [31:0] cz_s1    [NUM_ITER+1];
	logic [1:0]         quad_s1  [NUM_ITER+1];
	sprite_t            spr_s1   [NUM_ITER+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1[0] <= 1'b0;
		end else begin
			v_s1[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cx_s1[0]   <= CORDIC_INIT_X;
			cy_s1[0]   <= '0;
			cz_s1[0]   <= resid_in;
			quad_s1[0] <= quad_in;
			spr_s1[0]  <= sprite;
		end
	end

	for (genvar k = 0; k < NUM_ITER; k++) begin : g_iter
		logic signed [31:0] dx;
		logic signed [31:0] dy;

		// The arithmetic shifts round toward minus infinity.
		assign dx = cy_s1[k] >>> k;
		assign dy = cx_s1[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[k+1] <= 1'b0;
			end else begin
				v_s1[k+1] <= v_s1[k];
			end
		end

		always_ff @(posedge clk) begin
			if (v_s1[k]) begin
				if (!cz_s1[k][31]) begin
					cx_s1[k+1] <= cx_s1[k] - dx;
					cy_s1[k+1] <= cy_s1[k] + dy;
					cz_s1[k+1] <= cz_s1[k] - ATAN_PHASE[k];
				end else begin
					cx_s1[k+1] <= cx_s1[k] + dx;
					cy_s1[k+1] <= cy_s1[k] - dy;
					cz_s1[k+1] <= cz_s1[k] + ATAN_PHASE[k];
				end
				quad_s1[k+1] <= quad_s1[k];
				spr_s1[k+1]  <= spr_s1[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: the quarter turn is applied to give cos and sin in Q2.30,
	// and each is multiplied by the full width and height. The corner
	// signs are applied later, so four products serve all four corners.
	// ------------------------------------------------------------------
	logic signed [31:0] cos_v;
	logic signed [31:0] sin_v;

	always_comb begin
		case (quad_s1[NUM_ITER])
			QUAD_EAST: begin
				cos_v = cx_s1[NUM_ITER];
				sin_v = cy_s1[NUM_ITER];
			end
			QUAD_NORTH: begin
				cos_v = -cy_s1[NUM_ITER];
				sin_v = cx_s1[NUM_ITER];
			end
			QUAD_WEST: begin
				cos_v = -cx_s1[NUM_ITER];
				sin_v = -cy_s1[NUM_ITER];
			end
			default: begin
				cos_v = cy_s1[NUM_ITER];
				sin_v = -cx_s1[NUM_ITER];
			end
		endcase
	end

	logic               v_s2;
	logic signed [63:0] cw_s2;
	logic signed [63:0] sw_s2;
	logic signed [63:0] ch_s2;
	logic signed [63:0] sh_s2;
	sprite_t            spr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1[NUM_ITER];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1[NUM_ITER]) begin
			cw_s2  <= cos_v * spr_s1[NUM_ITER].size_x;
			sw_s2  <= sin_v * spr_s1[NUM_ITER].size_x;
			ch_s2  <= cos_v * spr_s1[NUM_ITER].size_y;
			sh_s2  <= sin_v * spr_s1[NUM_ITER].size_y;
			spr_s2 <= spr_s1[NUM_ITER];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: per corner, x = sx*c*w - sy*s*h and y = sx*s*w + sy*c*h,
	// plus the rounding half. The sums are exact in 66 bits, including the
	// negation of the most negative size.
	// ------------------------------------------------------------------
	logic               v_s3;
	logic signed [65:0] rx_s3 [4];
	logic signed [65:0] ry_s3 [4];
	sprite_t            spr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	for (genvar n = 0; n < 4; n++) begin : g_corner
		// Corners 0 and 3 sit at minus half width, corners 0 and 1 at minus half height.
		localparam bit SX_NEG = (n == 0) || (n == 3);
		localparam bit SY_NEG = (n == 0) || (n == 1);

		logic signed [65:0] cw_e;
		logic signed [65:0] sw_e;
		logic signed [65:0] ch_e;
		logic signed [65:0] sh_e;

		assign cw_e = 66'(cw_s2);
		assign sw_e = 66'(sw_s2);
		assign ch_e = 66'(ch_s2);
		assign sh_e = 66'(sh_s2);

		always_ff @(posedge clk) begin
			if (v_s2) begin
				rx_s3[n] <= (SX_NEG ? -cw_e : cw_e) + (SY_NEG ? sh_e : -sh_e) + ROUND_HALF;
				ry_s3[n] <= (SX_NEG ? -sw_e : sw_e) + (SY_NEG ? -ch_e : ch_e) + ROUND_HALF;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			spr_s3 <= spr_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: drop 47 fraction bits (30 for the Q2.30 scale, one for the half-size
	// factor and 16 more), add the center and saturate to 32 bits.
	// ------------------------------------------------------------------
	function automatic logic signed [31:0] place(input logic signed [65:0] sum,
		input logic signed [31:0] pos);
		logic signed [33:0] t;
		logic signed [31:0] r;
		t = 34'($signed(sum[65:47])) + 34'(pos);
		if (t[33:31] == 3'b000 || t[33:31] == 3'b111) begin
			r = t[31:0];
		end else if (t[33]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

	logic               v_s4;
	logic signed [31:0] px_s4 [4];
	logic signed [31:0] py_s4 [4];
	sprite_t            spr_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			for (int n = 0; n < 4; n++) begin
				px_s4[n] <= place(rx_s3[n], spr_s3.pos_x);
				py_s4[n] <= place(ry_s3[n], spr_s3.pos_y);
			end
			spr_s4 <= spr_s3;
		end
	end

	// ------------------------------------------------------------------
	// Serializer. A finished quad is copied into a hold register and sent
	// out as six vertices on consecutive cycles. A new quad may land in the
	// hold register on the same edge that sends the last vertex of the
	// previous one, which the input spacing makes the closest case.
	// ------------------------------------------------------------------
	logic               active_q;
	logic [SLOT_W-1:0]  slot_q;
	logic signed [31:0] hx_q [4];
	logic signed [31:0] hy_q [4];
	sprite_t            hspr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			slot_q   <= '0;
		end else if (v_s4) begin
			active_q <= 1'b1;
			slot_q   <= '0;
		end else if (active_q) begin
			if (slot_q == LAST_SLOT) begin
				active_q <= 1'b0;
				slot_q   <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			hx_q   <= px_s4;
			hy_q   <= py_s4;
			hspr_q <= spr_s4;
		end
	end

	// Vertex of the current slot, taken from the hold register.
	logic [1:0] corner;
	vertex_t    vert_next;

	assign corner = slot_corner(slot_q);

	always_comb begin
		vert_next.vert_x      = hx_q[corner];
		vert_next.vert_y      = hy_q[corner];
		vert_next.vert_u      = (corner == CORNER_0 || corner == CORNER_3) ? hspr_q.tex_u0
			: hspr_q.tex_u1;
		vert_next.vert_v      = (corner == CORNER_0 || corner == CORNER_1) ? hspr_q.tex_v0
			: hspr_q.tex_v1;
		vert_next.vert_color  = hspr_q.color_rgba;
		vert_next.vert_slot   = slot_q;
		vert_next.last_vertex = (slot_q == LAST_SLOT);
	end

	// Output register: each vertex is shown for exactly one cycle.
	logic    strobe_q;
	vertex_t vertex_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (active_q) begin
			vertex_q <= vert_next;
		end
	end

	assign strobe = strobe_q;
	assign vertex = vertex_q;

endmodule

[sim/vertex_checker.sv]
// Watches the sprite and vertex channels of the quad vertex generator, predicts the six
// vertices of every accepted sprite and compares them in order with what comes out.
module vertex_checker
	import rqvg_pkg::*;
#(
	parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
	parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  sprite_t sprite,
	input  logic    strobe,
	input  vertex_t vertex,
	output int      errors,
	output int      pending
);

	localparam longint Q16_MAX = 64'sd2147483647;
	localparam longint Q16_MIN = -64'sd2147483648;

	localparam logic [1:0] TRIANGLE_CORNER [VERTS] = '{
		CORNER_0, CORNER_1, CORNER_2, CORNER_0, CORNER_2, CORNER_3
	};

	vertex_t expected_verts [$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	// Rotation-mode CORDIC on the residual angle, then the quadrant by swap and negate.
	function automatic void rotate_unit(input logic [31:0] phase,
			output longint cos_q, output longint sin_q);
		logic [31:0] rounded;
		logic [1:0]  quadrant;
		logic [31:0] resid;
		longint      x, y, z, dx, dy;
		int          i;
		rounded  = phase + 32'h2000_0000;
		quadrant = rounded[31:30];
		resid    = phase - {quadrant, 30'd0};
		z = longint'($signed(resid));
		x = longint'(CORDIC_INIT_X);
		y = 0;
		for (i = 0; i < TRIG_ITERATIONS && i < ATAN_ENTRIES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(ATAN_PHASE[i]);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(ATAN_PHASE[i]);
			end
		end
		case (quadrant)
			QUAD_EAST: begin
				cos_q = x;
				sin_q = y;
			end
			QUAD_NORTH: begin
				cos_q = -y;
				sin_q = x;
			end
			QUAD_WEST: begin
				cos_q = -x;
				sin_q = -y;
			end
			default: begin
				cos_q = y;
				sin_q = -x;
			end
		endcase
	endfunction

	function automatic logic signed [31:0] clamp_q16(input longint v);
		if (v > Q16_MAX)
			return 32'sh7FFF_FFFF;
		if (v < Q16_MIN)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	task automatic predict_quad(input sprite_t s);
		logic [31:0] keep;
		logic [31:0] phase;
		longint      c, sn, px, py, wx, wy, lx, ly, rx, ry;
		logic [1:0]  corner;
		vertex_t     v;
		int          k;
		keep  = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
		phase = {s.angle, 16'd0} & keep;
		rotate_unit(phase, c, sn);
		px = longint'($signed(s.pos_x));
		py = longint'($signed(s.pos_y));
		wx = longint'($signed(s.size_x));
		wy = longint'($signed(s.size_y));
		for (k = 0; k < VERTS; k++) begin
			corner = TRIANGLE_CORNER[k];
			lx = (corner == CORNER_0 || corner == CORNER_3) ? -wx : wx;
			ly = (corner == CORNER_0 || corner == CORNER_1) ? -wy : wy;
			// Dividing by 2^47 drops the Q2.30 scale, the half-size factor and 16 more bits.
			rx = (c * lx - sn * ly + (64'sd1 <<< 46)) >>> 47;
			ry = (sn * lx + c * ly + (64'sd1 <<< 46)) >>> 47;
			v.vert_x      = clamp_q16(rx + px);
			v.vert_y      = clamp_q16(ry + py);
			v.vert_u      = (corner == CORNER_0 || corner == CORNER_3) ? s.tex_u0 : s.tex_u1;
			v.vert_v      = (corner == CORNER_0 || corner == CORNER_1) ? s.tex_v0 : s.tex_v1;
			v.vert_color  = s.color_rgba;
			v.vert_slot   = SLOT_W'(k);
			v.last_vertex = (SLOT_W'(k) == LAST_SLOT);
			expected_verts = {expected_verts, v};
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, actual %h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		vertex_t want;
		if (arst_n) begin
			if (strobe) begin
				if (expected_verts.size() == 0) begin
					$error("vertex transfer with nothing expected: slot %0d", vertex.vert_slot);
					errors++;
				end else begin
					want = expected_verts.pop_front();
					check_field("vert_x", want.vert_x, vertex.vert_x);
					check_field("vert_y", want.vert_y, vertex.vert_y);
					check_field("vert_u", want.vert_u, vertex.vert_u);
					check_field("vert_v", want.vert_v, vertex.vert_v);
					check_field("vert_color", want.vert_color, vertex.vert_color);
					check_field("vert_slot", 32'(want.vert_slot), 32'(vertex.vert_slot));
					check_field("last_vertex", 32'(want.last_vertex),
						32'(vertex.last_vertex));
				end
			end
			if (start && !busy)
				predict_quad(sprite);
			pending <= expected_verts.size();
		end
	end

endmodule

[sim/testbench.sv]
// Top of the quad vertex generator bench. It produces sprites, leaves all prediction and
// comparison to the checker beside the block, and gives the verdict at the end.
module testbench;
	import rqvg_pkg::*;

	// Sized from the pipeline depth and the six vertices of one quad, plus a margin, so
	// this covers the tail of the last sprite.
	localparam int DRAIN_CYCLES  = TRIG_ITER_DEF + 5 + VERTS + 8;
	// Cycles without any transfer on either channel before the run is declared hung.
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 192;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	sprite_t sprite;
	logic    strobe;
	vertex_t vertex;
	int      errors;
	int      pending;
	int      idle_run;
	logic    burst_mode;

	rotated_quad_vertex_generator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sprite (sprite),
		.strobe (strobe),
		.vertex (vertex)
	);

	vertex_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.sprite  (sprite),
		.strobe  (strobe),
		.vertex  (vertex),
		.errors  (errors),
		.pending (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: any cycle with a transfer on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			idle_run <= 0;
		end else begin
			idle_run <= idle_run + 1;
			if (idle_run + 1 >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	function automatic sprite_t make_sprite(input logic [31:0] px, input logic [31:0] py,
			input logic [15:0] ang, input logic [31:0] sx, input logic [31:0] sy,
			input logic [31:0] u0, input logic [31:0] v0, input logic [31:0] u1,
			input logic [31:0] v1, input logic [31:0] col);
		sprite_t s;
		s.pos_x      = px;
		s.pos_y      = py;
		s.angle      = ang;
		s.size_x     = sx;
		s.size_y     = sy;
		s.tex_u0     = u0;
		s.tex_v0     = v0;
		s.tex_u1     = u1;
		s.tex_v1     = v1;
		s.color_rgba = col;
		return s;
	endfunction

	// Signed random value with its magnitude cut down by an arithmetic shift.
	function automatic logic [31:0] scaled_rand(input int shift);
		logic signed [31:0] r;
		r = $signed($urandom);
		return r >>> shift;
	endfunction

	// Hands one sprite over. The sender idles a random number of cycles first, except in
	// burst stretches, and then holds start until the block takes the transfer.
	task automatic send_sprite(input sprite_t s);
		int gap;
		if ($urandom_range(0, 9) == 0)
			burst_mode = ~burst_mode;
		gap = burst_mode ? 0 : $urandom_range(0, 8);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start  <= 1'b1;
		sprite <= s;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic send_random_sprite();
		sprite_t s;
		s = make_sprite($urandom, $urandom, 16'($urandom), $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom);
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				// Fully random fields; a position saturates only when its center lies close to a rail.
			end
			3, 4, 5, 6, 7: begin
				// Ordinary sprites: positions and sizes well inside the Q16.16 range.
				s.pos_x  = scaled_rand(8);
				s.pos_y  = scaled_rand(8);
				s.size_x = scaled_rand(10);
				s.size_y = scaled_rand(10);
			end
			default: begin
				// Centers close to either rail so that some corners clip and some do not.
				s.pos_x  = ($urandom_range(0, 1) ? 32'h7FFF_0000 : 32'h8001_0000)
					+ scaled_rand(12);
				s.pos_y  = ($urandom_range(0, 1) ? 32'h7FFF_0000 : 32'h8001_0000)
					+ scaled_rand(12);
				s.size_x = scaled_rand(4);
				s.size_y = scaled_rand(4);
			end
		endcase
		// Angles at and next to the multiples of an eighth turn; at the odd ones the quadrant changes.
		if ($urandom_range(0, 4) == 0)
			s.angle = 16'($urandom_range(0, 7) * 32'h2000 + $urandom_range(0, 2) - 1);
		send_sprite(s);
	endtask

	initial begin
		int n;
		arst_n     = 1'b0;
		start      = 1'b0;
		sprite     = '0;
		burst_mode = 1'b0;
		idle_run   = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed sprites: the four axis angles, the eighth-turn boundaries, the angle
		// extremes, the largest and most negative sizes, flipped quads, saturation of the
		// positions in both directions and extreme texture and color values.
		send_sprite('0);
		send_sprite(make_sprite(32'h0001_0000, 32'hFFFE_0000, 16'h0000, 32'h0004_0000,
			32'h0002_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'hFF00_00FF));
		send_sprite(make_sprite(32'h0001_0000, 32'hFFFE_0000, 16'h4000, 32'h0004_0000,
			32'h0002_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h00FF_00FF));
		send_sprite(make_sprite(32'h0001_0000, 32'hFFFE_0000, 16'h8000, 32'h0004_0000,
			32'h0002_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0000_FFFF));
		send_sprite(make_sprite(32'h0001_0000, 32'hFFFE_0000, 16'hC000, 32'h0004_0000,
			32'h0002_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h1234_5678));
		send_sprite(make_sprite(32'h0010_0000, 32'h0020_0000, 16'h2000, 32'h0008_0000,
			32'h0008_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0));
		send_sprite(make_sprite(32'h0010_0000, 32'h0020_0000, 16'hE000, 32'h0008_0000,
			32'h0003_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0));
		send_sprite(make_sprite(32'h0, 32'h0, 16'hFFFF, 32'h0100_0000, 32'h0080_0000,
			32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF));
		send_sprite(make_sprite(32'h0, 32'h0, 16'h0001, 32'h0100_0000, 32'h0080_0000,
			32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h8000_0001));
		send_sprite(make_sprite(32'h0003_8000, 32'hFFFF_4000, 16'h1555, 32'h0007_C000,
			32'h0002_2000, 32'h0000_4000, 32'h0000_8000, 32'h0000_C000, 32'h0001_0000,
			32'h5A5A_5A5A));
		send_sprite(make_sprite(32'h0, 32'h0, 16'h1000, 32'h8000_0000, 32'h8000_0000,
			32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0));
		send_sprite(make_sprite(32'h0, 32'h0, 16'h6000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0));
		send_sprite(make_sprite(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0));
		send_sprite(make_sprite(32'h8000_0000, 32'h8000_0000, 16'h0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0));
		send_sprite(make_sprite(32'h0005_0000, 32'h0005_0000, 16'h3000, 32'hFFFA_0000,
			32'hFFFC_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0));
		send_sprite(make_sprite(32'h0, 32'h0, 16'h0800, 32'h0002_0000, 32'h0002_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
		send_sprite(make_sprite(32'hFFF0_0000, 32'h0010_0000, 16'h9000, 32'hFFFF_0000,
			32'hFFFE_8000, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'hA5A5_A5A5));
		send_sprite(make_sprite(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 32'h8000_0000,
			32'h8000_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0));

		for (n = 0; n < RANDOM_ITEMS; n++)
			send_random_sprite();
		@(negedge clk);
		start <= 1'b0;

		// Let the last quads come out, then allow for anything left in flight.
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/rqvg_pkg.sv
hw/rtl/rotated_quad_vertex_generator.sv
sim/vertex_checker.sv
sim/testbench.sv
